/* hw/rtl/rlwq_pkg.sv */
// Shared constants, types and status codes of the recursive lock with wait queue.
package rlwq_pkg;

	localparam int QUEUE_DEPTH = 16;
	localparam int MAX_NEST    = 255;
	localparam int TID_W       = 8;
	localparam int NEST_W      = 8;
	localparam int STATUS_W    = 4;
	localparam int PTR_W       = $clog2(QUEUE_DEPTH);
	localparam int FILL_W      = $clog2(QUEUE_DEPTH + 1);
	localparam int MAP_DEPTH   = 2 ** TID_W;
	localparam int OUT_TDATA_W = ((TID_W + 1 + TID_W + NEST_W + FILL_W + 7) / 8) * 8;
	localparam int OUT_PAD_W   = OUT_TDATA_W - (TID_W + 1 + TID_W + NEST_W + FILL_W);

	typedef enum logic {
		CMD_ACQUIRE = 1'b0,
		CMD_RELEASE = 1'b1
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_ACQUIRED        = 4'd0,
		ST_REENTERED       = 4'd1,
		ST_QUEUED          = 4'd2,
		ST_NEST_DEC        = 4'd3,
		ST_RELEASED        = 4'd4,
		ST_NOT_HOLDER      = 4'd5,
		ST_ALREADY_WAITING = 4'd6,
		ST_QUEUE_FULL      = 4'd7,
		ST_NEST_OVERFLOW   = 4'd8
	} status_t;

	typedef enum logic {
		FSM_IDLE = 1'b0,
		FSM_EXEC = 1'b1
	} fsm_t;

endpackage

/* hw/rtl/recursive_lock_with_wait_queue.sv */
// Recursive lock with FIFO wait queue: memory-based queue and waiting map, direct handoff.
// A request is read into stage registers on accept; its result is registered on execute.
// Requests are taken one at a time, set by the read-modify-write of the queue memory
// and the waiting-map memory (read on accept, write back in the execute cycle).
// Reset clears lock, owner, nesting, queue pointers, fill and the waiting-map valid bits;
// queue memory contents are not cleared.
module recursive_lock_with_wait_queue import rlwq_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [TID_W-1:0]       s_axis_tdata,  // thread_id
	input  logic                   s_axis_tuser,  // command
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	// woken_thread, lock_held, holder_thread, nest_depth, waiting_count, zero pad
	output logic [OUT_TDATA_W-1:0] m_axis_tdata,
	output logic [STATUS_W:0]      m_axis_tuser   // status, woken_valid
);

	fsm_t state_q, state_nxt;

	logic [TID_W-1:0] fifo_mem [QUEUE_DEPTH];
	logic             map_mem  [MAP_DEPTH];
	logic [MAP_DEPTH-1:0] map_vld_q;

	logic              locked_q;
	logic [TID_W-1:0]  owner_q;
	logic [NEST_W-1:0] nest_q;
	logic [PTR_W-1:0]  head_q, tail_q;
	logic [FILL_W-1:0] fill_q;

	cmd_t             cmd_s1;
	logic [TID_W-1:0] tid_s1;
	logic             map_rd_s1;
	logic [TID_W-1:0] fifo_rd_s1;

	logic              out_valid_q;
	status_t           out_status_q;
	logic              out_woken_valid_q;
	logic [TID_W-1:0]  out_woken_q;

	logic              accept, can_load, exec_fire;
	status_t           status;
	logic              locked_nxt, woken_valid;
	logic [TID_W-1:0]  owner_nxt, woken;
	logic [NEST_W-1:0] nest_nxt;
	logic [PTR_W-1:0]  head_nxt, tail_nxt;
	logic [FILL_W-1:0] fill_nxt;
	logic              fifo_we, map_we, map_wd;
	logic [TID_W-1:0]  map_wa;

	function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] idx);
		if (idx == PTR_W'(QUEUE_DEPTH - 1)) begin
			return '0;
		end
		return idx + PTR_W'(1);
	endfunction

	assign accept    = s_axis_tvalid && s_axis_tready;
	assign can_load  = !out_valid_q || m_axis_tready;
	assign exec_fire = (state_q == FSM_EXEC) && can_load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FSM_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt     = state_q;
		s_axis_tready = 1'b0;
		case (state_q)
			FSM_IDLE: begin
				s_axis_tready = 1'b1;
				if (s_axis_tvalid) begin
					state_nxt = FSM_EXEC;
				end
			end
			FSM_EXEC: begin
				if (can_load) begin
					state_nxt = FSM_IDLE;
				end
			end
			default: state_nxt = FSM_IDLE;
		endcase
	end

	// read stage: fetch waiting bit of the requester and the queue head
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1     <= cmd_t'(s_axis_tuser);
			tid_s1     <= s_axis_tdata;
			map_rd_s1  <= map_mem[s_axis_tdata] && map_vld_q[s_axis_tdata];
			fifo_rd_s1 <= fifo_mem[head_q];
		end
	end

	always_comb begin
		status      = ST_NOT_HOLDER;
		locked_nxt  = locked_q;
		owner_nxt   = owner_q;
		nest_nxt    = nest_q;
		head_nxt    = head_q;
		tail_nxt    = tail_q;
		fill_nxt    = fill_q;
		woken_valid = 1'b0;
		woken       = '0;
		fifo_we     = 1'b0;
		map_we      = 1'b0;
		map_wa      = tid_s1;
		map_wd      = 1'b0;
		if (cmd_s1 == CMD_ACQUIRE) begin
			if (!locked_q) begin
				locked_nxt = 1'b1;
				owner_nxt  = tid_s1;
				nest_nxt   = NEST_W'(1);
				status     = ST_ACQUIRED;
			end else if (owner_q == tid_s1) begin
				if (nest_q >= NEST_W'(MAX_NEST)) begin
					status = ST_NEST_OVERFLOW;
				end else begin
					nest_nxt = nest_q + NEST_W'(1);
					status   = ST_REENTERED;
				end
			end else if (map_rd_s1) begin
				status = ST_ALREADY_WAITING;
			end else if (fill_q >= FILL_W'(QUEUE_DEPTH)) begin
				status = ST_QUEUE_FULL;
			end else begin
				fifo_we  = 1'b1;
				tail_nxt = next_slot(tail_q);
				fill_nxt = fill_q + FILL_W'(1);
				map_we   = 1'b1;
				map_wd   = 1'b1;
				status   = ST_QUEUED;
			end
		end else begin
			if (!locked_q || owner_q != tid_s1) begin
				status = ST_NOT_HOLDER;
			end else if (nest_q > NEST_W'(1)) begin
				nest_nxt = nest_q - NEST_W'(1);
				status   = ST_NEST_DEC;
			end else if (fill_q != '0) begin
				head_nxt    = next_slot(head_q);
				fill_nxt    = fill_q - FILL_W'(1);
				map_we      = 1'b1;
				map_wa      = fifo_rd_s1;
				owner_nxt   = fifo_rd_s1;
				nest_nxt    = NEST_W'(1);
				woken_valid = 1'b1;
				woken       = fifo_rd_s1;
				status      = ST_RELEASED;
			end else begin
				locked_nxt = 1'b0;
				owner_nxt  = '0;
				nest_nxt   = '0;
				status     = ST_RELEASED;
			end
		end
	end

	// write-back stage
	always_ff @(posedge clk) begin
		if (exec_fire && fifo_we) begin
			fifo_mem[tail_q] <= tid_s1;
		end
		if (exec_fire && map_we) begin
			map_mem[map_wa] <= map_wd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_vld_q <= '0;
			locked_q  <= 1'b0;
			owner_q   <= '0;
			nest_q    <= '0;
			head_q    <= '0;
			tail_q    <= '0;
			fill_q    <= '0;
		end else if (exec_fire) begin
			if (map_we) begin
				map_vld_q[map_wa] <= 1'b1;
			end
			locked_q <= locked_nxt;
			owner_q  <= owner_nxt;
			nest_q   <= nest_nxt;
			head_q   <= head_nxt;
			tail_q   <= tail_nxt;
			fill_q   <= fill_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (exec_fire) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (exec_fire) begin
			out_status_q      <= status;
			out_woken_valid_q <= woken_valid;
			out_woken_q       <= woken;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = {out_woken_valid_q, out_status_q};
	assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, fill_q, nest_q, owner_q, locked_q, out_woken_q};

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FILL_W'(QUEUE_DEPTH))
		else $error("wait queue fill above depth");

	a_free_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!locked_q |-> (fill_q == '0 && owner_q == '0 && nest_q == '0))
		else $error("free lock with holder state or waiters");

	a_held_nest: assert property (@(posedge clk) disable iff (!arst_n)
		locked_q |-> (nest_q != '0))
		else $error("held lock with zero nesting");

	a_handoff: assert property (@(posedge clk) disable iff (!arst_n)
		(exec_fire && woken_valid) |=> (locked_q && owner_q == out_woken_q))
		else $error("handoff did not pass ownership to woken thread");

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 100ps
// Testbench for the recursive lock with wait queue: directed and random requests, predictor checks.
module tb_top;
	import rlwq_pkg::*;

	localparam int SETTLE      = 6;
	localparam int HELD_LSB    = TID_W;
	localparam int HOLDER_LSB  = HELD_LSB + 1;
	localparam int DEPTH_LSB   = HOLDER_LSB + TID_W;
	localparam int WAITING_LSB = DEPTH_LSB + NEST_W;

	typedef struct {
		status_t            status;
		logic               woken_valid;
		logic [TID_W-1:0]   woken;
		logic               held;
		logic [TID_W-1:0]   holder;
		logic [NEST_W-1:0]  depth;
		logic [FILL_W-1:0]  waiting;
	} lock_result_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [TID_W-1:0]       s_axis_tdata = '0;
	logic                   s_axis_tuser = CMD_ACQUIRE;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic [STATUS_W:0]      m_axis_tuser;

	// lock state as the block should hold it
	logic                   lock_taken;
	logic [TID_W-1:0]       lock_owner;
	logic [NEST_W-1:0]      lock_nest;
	logic [TID_W-1:0]       waiters[$];
	logic                   is_waiting[MAP_DEPTH];

	lock_result_t           pending_results[$];
	int                     fail_count = 0;
	bit                     tx_steady = 1'b0;
	bit                     rx_steady = 1'b0;
	int                     rx_hold = 0;
	int                     rx_draw;

	recursive_lock_with_wait_queue u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic lock_result_t lock_step(cmd_t cmd, logic [TID_W-1:0] tid);
		lock_result_t r;
		r.status      = ST_NOT_HOLDER;
		r.woken_valid = 1'b0;
		r.woken       = '0;
		if (cmd == CMD_ACQUIRE) begin
			if (!lock_taken) begin
				lock_taken = 1'b1;
				lock_owner = tid;
				lock_nest  = NEST_W'(1);
				r.status   = ST_ACQUIRED;
			end else if (lock_owner == tid) begin
				if (lock_nest >= NEST_W'(MAX_NEST)) begin
					r.status = ST_NEST_OVERFLOW;
				end else begin
					lock_nest = lock_nest + NEST_W'(1);
					r.status  = ST_REENTERED;
				end
			end else if (is_waiting[tid]) begin
				r.status = ST_ALREADY_WAITING;
			end else if (waiters.size() >= QUEUE_DEPTH) begin
				r.status = ST_QUEUE_FULL;
			end else begin
				waiters.push_back(tid);
				is_waiting[tid] = 1'b1;
				r.status = ST_QUEUED;
			end
		end else begin
			if (!lock_taken || lock_owner != tid) begin
				r.status = ST_NOT_HOLDER;
			end else if (lock_nest > NEST_W'(1)) begin
				lock_nest = lock_nest - NEST_W'(1);
				r.status  = ST_NEST_DEC;
			end else if (waiters.size() != 0) begin
				lock_owner = waiters.pop_front();
				is_waiting[lock_owner] = 1'b0;
				lock_nest     = NEST_W'(1);
				r.woken_valid = 1'b1;
				r.woken       = lock_owner;
				r.status      = ST_RELEASED;
			end else begin
				lock_taken = 1'b0;
				lock_owner = '0;
				lock_nest  = '0;
				r.status   = ST_RELEASED;
			end
		end
		r.held    = lock_taken;
		r.holder  = lock_taken ? lock_owner : '0;
		r.depth   = lock_taken ? lock_nest : '0;
		r.waiting = FILL_W'(waiters.size());
		return r;
	endfunction

	function automatic void check_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fail_count++;
		end
	endfunction

	task automatic check_result();
		lock_result_t want;
		if (pending_results.size() == 0) begin
			$error("result transfer with no expectation waiting");
			fail_count++;
		end else begin
			want = pending_results.pop_front();
			check_field("status", want.status, m_axis_tuser[STATUS_W-1:0]);
			check_field("woken_valid", want.woken_valid, m_axis_tuser[STATUS_W]);
			check_field("woken_thread", want.woken, m_axis_tdata[TID_W-1:0]);
			check_field("lock_held", want.held, m_axis_tdata[HELD_LSB]);
			check_field("holder_thread", want.holder, m_axis_tdata[HOLDER_LSB +: TID_W]);
			check_field("nest_depth", want.depth, m_axis_tdata[DEPTH_LSB +: NEST_W]);
			check_field("waiting_count", want.waiting, m_axis_tdata[WAITING_LSB +: FILL_W]);
		end
	endtask

	// after each transfer, randomly deassert ready on the result side unless rx_steady is set
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			rx_hold       <= 0;
		end else if (m_axis_tvalid && m_axis_tready) begin
			check_result();
			rx_draw = rx_steady ? 0 : $urandom_range(0, 11);
			if (rx_draw != 0) begin
				m_axis_tready <= 1'b0;
				rx_hold       <= rx_draw;
			end
		end else if (!m_axis_tready) begin
			if (rx_hold <= 1)
				m_axis_tready <= 1'b1;
			if (rx_hold != 0)
				rx_hold <= rx_hold - 1;
		end
	end

	task automatic send_req(cmd_t cmd, logic [TID_W-1:0] tid);
		int gap;
		gap = tx_steady ? 0 : $urandom_range(0, 11);
		if (gap != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= tid;
		s_axis_tuser  <= cmd;
		do @(posedge clk); while (!s_axis_tready);
		pending_results.push_back(lock_step(cmd, tid));
	endtask

	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic test_ownership();
		send_req(CMD_ACQUIRE, 8'h00);
		send_req(CMD_ACQUIRE, 8'h00);
		send_req(CMD_RELEASE, 8'hFF);
		send_req(CMD_RELEASE, 8'h00);
		send_req(CMD_RELEASE, 8'h00);
		send_req(CMD_RELEASE, 8'h00);
	endtask

	task automatic test_wait_queue();
		send_req(CMD_ACQUIRE, 8'hA5);
		for (int k = 0; k < QUEUE_DEPTH; k++)
			send_req(CMD_ACQUIRE, TID_W'(8'h11 * k));
		send_req(CMD_ACQUIRE, 8'h33);
		send_req(CMD_ACQUIRE, 8'h42);
		send_req(CMD_RELEASE, 8'h00);
		send_req(CMD_RELEASE, 8'hA5);
		send_req(CMD_RELEASE, 8'h00);
		send_req(CMD_ACQUIRE, 8'h33);
		send_req(CMD_RELEASE, 8'h11);
		send_req(CMD_ACQUIRE, 8'h00);
	endtask

	function automatic logic [TID_W-1:0] pick_thread();
		if ($urandom_range(0, 4) == 0)
			return TID_W'($urandom_range(0, 255));
		return TID_W'($urandom_range(0, 23));
	endfunction

	task automatic test_random_traffic(int count);
		int r;
		for (int i = 0; i < count; i++) begin
			if (i % 50 == 0) begin
				tx_steady = ($urandom_range(0, 3) == 0);
				rx_steady = ($urandom_range(0, 3) == 0);
			end
			if (i == count / 2)
				drain_results();
			r = $urandom_range(0, 99);
			if (r < 30)
				send_req(CMD_ACQUIRE, pick_thread());
			else if (r < 40)
				send_req(CMD_ACQUIRE, lock_taken ? lock_owner : pick_thread());
			else if (r < 75)
				send_req(CMD_RELEASE, lock_taken ? lock_owner : pick_thread());
			else if (r < 85)
				send_req(CMD_RELEASE, pick_thread());
			else
				send_req(cmd_t'($urandom_range(0, 1)), TID_W'($urandom_range(0, 255)));
		end
	endtask

	task automatic test_nest_saturation();
		logic [TID_W-1:0] tid;
		tx_steady = 1'b0;
		rx_steady = 1'b1;
		if (!lock_taken)
			send_req(CMD_ACQUIRE, 8'h7E);
		tid = lock_owner;
		while (lock_nest < NEST_W'(MAX_NEST))
			send_req(CMD_ACQUIRE, tid);
		send_req(CMD_ACQUIRE, tid);
		send_req(CMD_ACQUIRE, tid);
		send_req(CMD_RELEASE, tid);
		send_req(CMD_ACQUIRE, tid);
	endtask

	initial begin
		lock_taken = 1'b0;
		lock_owner = '0;
		lock_nest  = '0;
		foreach (is_waiting[i])
			is_waiting[i] = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_ownership();
		test_wait_queue();
		test_random_traffic(260);
		test_nest_saturation();
		drain_results();
		if (fail_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	initial begin
		#1000000;
		$display("TB_ERROR");
		$finish;
	end

endmodule
